>>> rtl/u2u_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 (BMP) decoder.
`default_nettype none

package u2u_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned UNIT_W    = 16;
  localparam int unsigned PARTIAL_W = 10;
  localparam int unsigned AWAIT_W   = 2;

  // continuation bytes still expected
  localparam logic [AWAIT_W-1:0] AWAIT_NONE = 2'd0;
  localparam logic [AWAIT_W-1:0] AWAIT_ONE  = 2'd1;
  localparam logic [AWAIT_W-1:0] AWAIT_TWO  = 2'd2;

  localparam logic [BYTE_W-1:0] BYTE_NUL      = 8'h00;
  localparam logic [BYTE_W-1:0] ASCII_MAX     = 8'h7F;
  localparam logic [BYTE_W-1:0] CONT_MIN      = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_MAX      = 8'hBF;
  localparam logic [BYTE_W-1:0] LEAD2_MIN     = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD2_MAX     = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_MIN     = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_MAX     = 8'hEF;

  typedef struct packed {
    logic [AWAIT_W-1:0]   awaited;
    logic [PARTIAL_W-1:0] partial;
  } dec_state_t;

  typedef struct packed {
    logic                 emit;
    logic [UNIT_W-1:0]    code_unit;
    dec_state_t           state_nxt;
  } dec_result_t;

endpackage

`default_nettype wire

>>> rtl/utf8_to_utf16_bmp_decoder_unit.sv
// Top level of the UTF-8 to UTF-16 (BMP) stream decoder.
// Takes one UTF-8 byte per transfer and gives one 16-bit code unit per
// completed one-, two- or three-byte sequence. Throughput is one byte per
// clock while the output is not stalled: a byte passes an input register, one
// decode step that updates the pending-sequence state, and an output register
// that drives out_tvalid.
// A 0x00 byte ends the string and
// clears any pending sequence without a result. Lone continuation bytes and
// leads 0xF0-0xFF are dropped; a non-continuation byte inside a sequence
// drops that sequence and is decoded afresh. Overlong forms and surrogate
// values pass unchecked. Backpressure on the output stalls the decode step
// and, through it, in_tready.
`default_nettype none

module utf8_to_utf16_bmp_decoder_unit
  import u2u_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // [15:0] code_unit
);

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              step;

  dec_state_t  state_r;
  dec_state_t  state_nxt;
  dec_result_t dec_res;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [UNIT_W-1:0] out_data_r;

  // decode step fires when a byte is held and the output slot is free
  assign step = s1_valid && (!out_valid_r || out_tready);

  u2u_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .hold_valid (s1_valid),
    .hold_byte  (s1_byte),
    .hold_take  (step)
  );

  u2u_decode u_decode (
    .byte_i   (s1_byte),
    .state_i  (state_r),
    .result_o (dec_res)
  );

  assign state_nxt     = step ? dec_res.state_nxt : state_r;
  assign out_valid_nxt = step ? dec_res.emit : (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // code unit register: loaded only when a result is produced
  always_ff @(posedge clk) begin
    if (step && dec_res.emit) begin
      out_data_r <= dec_res.code_unit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // the pending count never reaches three
  a_await_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.awaited != 2'd3)
    else $error("pending count out of range");

  // a held byte waits while the output slot is blocked
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && out_valid_r && !out_tready) |=> (s1_valid && $stable(s1_byte)))
    else $error("held byte lost during output stall");

  // a produced result shows up on the output next cycle
  a_emit_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (step && dec_res.emit) |=> out_valid_r)
    else $error("decoded result not presented");

  // end of string leaves nothing pending
  a_nul_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (s1_byte == BYTE_NUL)) |=> (state_r.awaited == AWAIT_NONE))
    else $error("end of string left a sequence pending");
`endif

endmodule

`default_nettype wire

>>> rtl/u2u_in_reg.sv
// Input register stage: holds one byte until the decode step consumes it.
`default_nettype none

module u2u_in_reg
  import u2u_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_byte,
  output logic                   hold_valid,
  output logic [BYTE_W-1:0]      hold_byte,
  input  wire logic              hold_take
);

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] byte_r;

  // accept when empty, or when the held byte leaves this cycle
  assign in_ready  = !valid_r || hold_take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !hold_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

endmodule

`default_nettype wire

>>> rtl/u2u_decode.sv
// Combinational decode step: one byte against the pending-sequence state.
`default_nettype none

module u2u_decode
  import u2u_pkg::*;
(
  input  wire logic [BYTE_W-1:0] byte_i,
  input  wire dec_state_t        state_i,
  output dec_result_t            result_o
);

  logic              is_cont;
  logic [UNIT_W-1:0] merged;

  assign is_cont = (byte_i >= CONT_MIN) && (byte_i <= CONT_MAX);
  assign merged  = {state_i.partial, byte_i[5:0]};

  always_comb begin
    result_o.emit              = 1'b0;
    result_o.code_unit         = merged;
    result_o.state_nxt.awaited = AWAIT_NONE;
    result_o.state_nxt.partial = '0;

    if ((state_i.awaited != AWAIT_NONE) && is_cont) begin
      if (state_i.awaited == AWAIT_ONE) begin
        result_o.emit = 1'b1;
      end else begin
        // first of two continuations (a count of 3 behaves the same)
        result_o.state_nxt.awaited = AWAIT_ONE;
        result_o.state_nxt.partial = merged[PARTIAL_W-1:0];
      end
    end else begin
      // nothing pending, or broken sequence: decode the byte afresh
      priority if (byte_i == BYTE_NUL) begin
        result_o.emit = 1'b0;
      end else if (byte_i <= ASCII_MAX) begin
        result_o.emit      = 1'b1;
        result_o.code_unit = {{(UNIT_W-BYTE_W){1'b0}}, byte_i};
      end else if ((byte_i >= LEAD2_MIN) && (byte_i <= LEAD2_MAX)) begin
        result_o.state_nxt.awaited = AWAIT_ONE;
        result_o.state_nxt.partial = {{(PARTIAL_W-5){1'b0}}, byte_i[4:0]};
      end else if ((byte_i >= LEAD3_MIN) && (byte_i <= LEAD3_MAX)) begin
        result_o.state_nxt.awaited = AWAIT_TWO;
        result_o.state_nxt.partial = {{(PARTIAL_W-4){1'b0}}, byte_i[3:0]};
      end else begin
        // lone continuation or lead 0xF0-0xFF: dropped
        result_o.emit = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
